// ===== rtl/core/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

    // Field widths of one item, fixed by the command and result formats.
    localparam int OPCODE_W = 2;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // One command item.
    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] item_value;
    } pal_cmd_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data_out;
        logic [COUNT_W-1:0]       count;
        logic                     empty_flag;
        logic                     full_flag;
    } pal_result_t;

endpackage

// ===== rtl/core/positional_array_list.sv =====
`timescale 1ns / 1ps

// Positional array list: an ordered list of up to CAPACITY signed words kept
// in a single-port-write, single-port-read memory. A command is taken when
// start is high and busy is low; its result appears for exactly one cycle
// with done high and must be captured then, since the block cannot be held
// off. All entry moves go through the one memory port pair, one entry at a
// time (read, then write), so the time from accept to done depends on how
// many entries move, that is on the length and the position. busy stays
// high while a command is in flight and is low again in the cycle done is
// high, so a new command may be given in the cycle done is high.
// The count field reports the length in 6 bits.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  pal_cmd_t    cmd,
    output logic        done,
    output pal_result_t result
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_CAPT  = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic [OPCODE_W-1:0]      op_reg, op_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [WORD_W-1:0] val_reg, val_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    logic                     done_reg, done_next;
    pal_result_t              result_reg, result_next;

    logic [WORD_W-1:0]        mem [CAPACITY];
    logic [WORD_W-1:0]        rdata_reg;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [WORD_W-1:0]        wr_data;

    logic [CMPW-1:0]          pos_ext;
    logic [CMPW-1:0]          cnt_ext;
    logic                     is_full;
    logic [CW:0]              idx_plus2;
    logic [CW:0]              pos_plus1;
    logic [CW-1:0]            idx_dec;
    logic [CW-1:0]            count_upd;

    assign pos_ext   = CMPW'(cmd.position);
    assign cnt_ext   = CMPW'(count_reg);
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign idx_plus2 = {1'b0, idx_reg} + (CW+1)'(2);
    assign pos_plus1 = {1'b0, pos_reg} + (CW+1)'(1);
    assign idx_dec   = idx_reg - CW'(1);

    // Sequencer: validates the command, then moves entries one at a time.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        status_next = status_reg;
        val_next    = val_reg;
        data_next   = data_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rdata_reg;
        count_upd   = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.opcode;
                    pos_next    = CW'(cmd.position);
                    val_next    = cmd.item_value;
                    idx_next    = count_reg;
                    data_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    if (cmd.opcode == OP_INSERT)
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (pos_ext > cnt_ext)
                        begin
                            status_next = ST_INDEX;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else if (cmd.opcode == OP_DELETE || cmd.opcode == OP_READ)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (pos_ext >= cnt_ext)
                        begin
                            status_next = ST_INDEX;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            // Read the neighbor that moves into the slot at idx.
            S_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = (op_reg == OP_INSERT) ? idx_dec[AW-1:0]
                                                   : idx_plus2[AW-1:0] - AW'(1);
                state_next = S_WRITE;
            end

            // Write it into idx and step toward the end of the move.
            S_WRITE:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = rdata_reg;
                if (op_reg == OP_INSERT)
                begin
                    idx_next   = idx_dec;
                    state_next = (idx_dec > pos_reg) ? S_READ : S_PUT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = (idx_plus2 < {1'b0, count_reg}) ? S_READ : S_DONE;
                end
            end

            // Fetch the addressed entry for a read or delete.
            S_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg[AW-1:0];
                state_next = S_CAPT;
            end

            S_CAPT:
            begin
                data_next = rdata_reg;
                idx_next  = pos_reg;
                if (op_reg == OP_DELETE && pos_plus1 < {1'b0, count_reg})
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Drop the new word into the opened slot.
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = val_reg;
                state_next = S_DONE;
            end

            // Commit the length and present the result.
            S_DONE:
            begin
                if (status_reg == ST_OK && op_reg == OP_INSERT)
                begin
                    count_upd = count_reg + CW'(1);
                end
                else if (status_reg == ST_OK && op_reg == OP_DELETE)
                begin
                    count_upd = count_reg - CW'(1);
                end
                count_next             = count_upd;
                result_next.status     = status_reg;
                result_next.data_out   = data_reg;
                result_next.count      = COUNT_W'(count_upd);
                result_next.empty_flag = (count_upd == '0);
                result_next.full_flag  = (count_upd == CW'(CAPACITY));
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers of the item in flight.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        data_reg   <= data_next;
        result_reg <= result_next;
    end

    // Entry storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result only follows the commit state.
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DONE))
        else $error("done without a commit cycle");

    // The length never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A successful insert grows the list by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK && op_reg == OP_INSERT)
            |-> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    // A rejected command leaves the length alone.
    a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> count_reg == $past(count_reg))
        else $error("rejected command changed the list length");

endmodule
